[sv/cfde_pkg.sv]
// shared types and constants of the cube face direction encode unit
`default_nettype none

package cfde_pkg;

   localparam int FACE_WIDTH  = 3;
   localparam int COORD_WIDTH = 32;

   localparam logic [FACE_WIDTH-1:0] FACE_NONE  = 3'd0;
   localparam logic [FACE_WIDTH-1:0] FACE_POS_X = 3'd1;
   localparam logic [FACE_WIDTH-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_WIDTH-1:0] FACE_POS_Z = 3'd3;
   localparam logic [FACE_WIDTH-1:0] FACE_NEG_Z = 3'd4;
   localparam logic [FACE_WIDTH-1:0] FACE_NEG_Y = 3'd5;
   localparam logic [FACE_WIDTH-1:0] FACE_NEG_X = 3'd6;

   // control that rides alongside the data down the divider chain
   typedef struct packed {
      logic                  valid;
      logic [FACE_WIDTH-1:0] face;
      logic                  neg_u;
      logic                  neg_v;
   } cfde_ctrl_type;

endpackage

`default_nettype wire

[sv/cfde_select.sv]
// magnitude split, major axis pick and divider setup, two register stages
`default_nettype none

module cfde_select import cfde_pkg::*; #(
   parameter int COMP_WIDTH = 32,
   parameter int FRAC_BITS  = 30
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         load,
   input  wire logic signed [COMP_WIDTH-1:0] comp_x,
   input  wire logic signed [COMP_WIDTH-1:0] comp_y,
   input  wire logic signed [COMP_WIDTH-1:0] comp_z,
   output      logic [COMP_WIDTH-1:0]        rem_u,
   output      logic [COMP_WIDTH-1:0]        rem_v,
   output      logic [FRAC_BITS:0]           quo_u,
   output      logic [FRAC_BITS:0]           quo_v,
   output      logic [COMP_WIDTH-1:0]        den,
   output      cfde_ctrl_type                ctrl
);

   localparam int QW = FRAC_BITS + 1;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // stage a: sign and exact magnitude of each component
   logic [COMP_WIDTH-1:0] mag_x_in, mag_y_in, mag_z_in;
   logic [COMP_WIDTH-1:0] mag_x_ff, mag_y_ff, mag_z_ff;
   logic [2:0]            neg_in, neg_ff;
   logic                  valid_a_ff;

   always_comb begin
      neg_in   = {comp_z[COMP_WIDTH-1], comp_y[COMP_WIDTH-1], comp_x[COMP_WIDTH-1]};
      mag_x_in = neg_in[0] ? (~$unsigned(comp_x) + COMP_WIDTH'(1)) : $unsigned(comp_x);
      mag_y_in = neg_in[1] ? (~$unsigned(comp_y) + COMP_WIDTH'(1)) : $unsigned(comp_y);
      mag_z_in = neg_in[2] ? (~$unsigned(comp_z) + COMP_WIDTH'(1)) : $unsigned(comp_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      mag_z_ff <= mag_z_in;
      neg_ff   <= neg_in;
   end

   // stage b: major axis, operands and the integer quotient bit
   logic [1:0]            major;
   logic                  is_zero;
   logic [COMP_WIDTH-1:0] num_u, num_v, den_sel;
   logic                  neg_major, neg_nxt, neg_oth;
   logic [FACE_WIDTH-1:0] face_sel;
   logic                  hit_u, hit_v;

   logic [COMP_WIDTH-1:0] rem_u_in, rem_v_in, den_in;
   logic [COMP_WIDTH-1:0] rem_u_ff, rem_v_ff, den_ff;
   logic [QW-1:0]         quo_u_in, quo_v_in, quo_u_ff, quo_v_ff;
   cfde_ctrl_type         ctrl_in, ctrl_ff;

   always_comb begin
      is_zero = (mag_x_ff == '0) && (mag_y_ff == '0) && (mag_z_ff == '0);
      if ((mag_z_ff >= mag_x_ff) && (mag_z_ff >= mag_y_ff)) begin
         major = AXIS_Z;
      end else if (mag_y_ff >= mag_x_ff) begin
         major = AXIS_Y;
      end else begin
         major = AXIS_X;
      end

      case (major)
         AXIS_X: begin
            num_u     = mag_y_ff;
            num_v     = mag_z_ff;
            den_sel   = mag_x_ff;
            neg_major = neg_ff[0];
            neg_nxt   = neg_ff[1];
            neg_oth   = neg_ff[2];
            face_sel  = neg_ff[0] ? FACE_NEG_X : FACE_POS_X;
         end
         AXIS_Y: begin
            num_u     = mag_z_ff;
            num_v     = mag_x_ff;
            den_sel   = mag_y_ff;
            neg_major = neg_ff[1];
            neg_nxt   = neg_ff[2];
            neg_oth   = neg_ff[0];
            face_sel  = neg_ff[1] ? FACE_NEG_Y : FACE_POS_Y;
         end
         default: begin
            num_u     = mag_x_ff;
            num_v     = mag_y_ff;
            den_sel   = mag_z_ff;
            neg_major = neg_ff[2];
            neg_nxt   = neg_ff[0];
            neg_oth   = neg_ff[1];
            face_sel  = neg_ff[2] ? FACE_NEG_Z : FACE_POS_Z;
         end
      endcase

      // zero vector divides 0 by 1 so the chain yields zero
      if (is_zero) begin
         num_u    = '0;
         num_v    = '0;
         den_sel  = COMP_WIDTH'(1);
         face_sel = FACE_NONE;
      end

      // numerator never exceeds the major magnitude, so the integer bit is equality
      hit_u    = (num_u == den_sel);
      hit_v    = (num_v == den_sel);
      rem_u_in = hit_u ? '0 : num_u;
      rem_v_in = hit_v ? '0 : num_v;
      quo_u_in = QW'(hit_u);
      quo_v_in = QW'(hit_v);
      den_in   = den_sel;

      ctrl_in.valid = valid_a_ff;
      ctrl_in.face  = face_sel;
      ctrl_in.neg_u = neg_nxt;
      ctrl_in.neg_v = neg_oth ^ neg_major;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_u_ff <= rem_u_in;
      rem_v_ff <= rem_v_in;
      quo_u_ff <= quo_u_in;
      quo_v_ff <= quo_v_in;
      den_ff   <= den_in;
   end

   assign rem_u = rem_u_ff;
   assign rem_v = rem_v_ff;
   assign quo_u = quo_u_ff;
   assign quo_v = quo_v_ff;
   assign den   = den_ff;
   assign ctrl  = ctrl_ff;

endmodule

`default_nettype wire

[sv/cfde_div_cell.sv]
// one restoring division step for both coordinates, registered
`default_nettype none

module cfde_div_cell import cfde_pkg::*; #(
   parameter int COMP_WIDTH = 32,
   parameter int FRAC_BITS  = 30
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [COMP_WIDTH-1:0] rem_u_i,
   input  wire logic [COMP_WIDTH-1:0] rem_v_i,
   input  wire logic [FRAC_BITS:0]    quo_u_i,
   input  wire logic [FRAC_BITS:0]    quo_v_i,
   input  wire logic [COMP_WIDTH-1:0] den_i,
   input  wire cfde_ctrl_type         ctrl_i,
   output      logic [COMP_WIDTH-1:0] rem_u_o,
   output      logic [COMP_WIDTH-1:0] rem_v_o,
   output      logic [FRAC_BITS:0]    quo_u_o,
   output      logic [FRAC_BITS:0]    quo_v_o,
   output      logic [COMP_WIDTH-1:0] den_o,
   output      cfde_ctrl_type         ctrl_o
);

   localparam int QW = FRAC_BITS + 1;

   logic [COMP_WIDTH:0]   dbl_u, dbl_v, den_x;
   logic                  ge_u, ge_v;
   logic [COMP_WIDTH:0]   dif_u, dif_v;
   logic [COMP_WIDTH-1:0] rem_u_in, rem_v_in, rem_u_ff, rem_v_ff, den_ff;
   logic [QW-1:0]         quo_u_in, quo_v_in, quo_u_ff, quo_v_ff;
   cfde_ctrl_type         ctrl_ff;

   always_comb begin
      dbl_u    = {rem_u_i, 1'b0};
      dbl_v    = {rem_v_i, 1'b0};
      den_x    = {1'b0, den_i};
      ge_u     = (dbl_u >= den_x);
      ge_v     = (dbl_v >= den_x);
      dif_u    = dbl_u - den_x;
      dif_v    = dbl_v - den_x;
      // remainder stays below the divisor, so the low bits hold it
      rem_u_in = ge_u ? dif_u[COMP_WIDTH-1:0] : dbl_u[COMP_WIDTH-1:0];
      rem_v_in = ge_v ? dif_v[COMP_WIDTH-1:0] : dbl_v[COMP_WIDTH-1:0];
      quo_u_in = {quo_u_i[QW-2:0], ge_u};
      quo_v_in = {quo_v_i[QW-2:0], ge_v};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_i;
      end
   end

   always_ff @(posedge clock) begin
      rem_u_ff <= rem_u_in;
      rem_v_ff <= rem_v_in;
      quo_u_ff <= quo_u_in;
      quo_v_ff <= quo_v_in;
      den_ff   <= den_i;
   end

   assign rem_u_o = rem_u_ff;
   assign rem_v_o = rem_v_ff;
   assign quo_u_o = quo_u_ff;
   assign quo_v_o = quo_v_ff;
   assign den_o   = den_ff;
   assign ctrl_o  = ctrl_ff;

endmodule

`default_nettype wire

[sv/cube_face_direction_encode_unit.sv]
// top level of the cube face direction encode unit
// the result strobe rises once its accepted item has passed, in order, through
//   two setup stages, one divider cell per fraction bit and one output register
// throughput: one item per cycle; busy stays low and the receiver cannot stall
// reset (synchronous, active high) empties the pipeline; no results strobe until new items
`default_nettype none

module cube_face_direction_encode_unit import cfde_pkg::*; #(
   parameter int COMP_WIDTH = 32,
   parameter int FRAC_BITS  = 30
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire logic signed [COMP_WIDTH-1:0]  req_comp_x,
   input  wire logic signed [COMP_WIDTH-1:0]  req_comp_y,
   input  wire logic signed [COMP_WIDTH-1:0]  req_comp_z,
   output      logic                          rsp_valid,
   output      logic [FACE_WIDTH-1:0]         rsp_face,
   output      logic signed [COORD_WIDTH-1:0] rsp_coord_u,
   output      logic signed [COORD_WIDTH-1:0] rsp_coord_v
);

   localparam int QW      = FRAC_BITS + 1;
   localparam int XW      = (QW > COORD_WIDTH) ? QW : COORD_WIDTH;
   localparam int LATENCY = FRAC_BITS + 3;

   logic [COMP_WIDTH-1:0] rem_u [0:FRAC_BITS];
   logic [COMP_WIDTH-1:0] rem_v [0:FRAC_BITS];
   logic [QW-1:0]         quo_u [0:FRAC_BITS];
   logic [QW-1:0]         quo_v [0:FRAC_BITS];
   logic [COMP_WIDTH-1:0] den   [0:FRAC_BITS];
   cfde_ctrl_type         ctrl  [0:FRAC_BITS];

   assign busy = 1'b0;

   cfde_select #(
      .COMP_WIDTH (COMP_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_select (
      .clock  (clock),
      .reset  (reset),
      .load   (start && !busy),
      .comp_x (req_comp_x),
      .comp_y (req_comp_y),
      .comp_z (req_comp_z),
      .rem_u  (rem_u[0]),
      .rem_v  (rem_v[0]),
      .quo_u  (quo_u[0]),
      .quo_v  (quo_v[0]),
      .den    (den[0]),
      .ctrl   (ctrl[0])
   );

   for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
      cfde_div_cell #(
         .COMP_WIDTH (COMP_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .rem_u_i (rem_u[i]),
         .rem_v_i (rem_v[i]),
         .quo_u_i (quo_u[i]),
         .quo_v_i (quo_v[i]),
         .den_i   (den[i]),
         .ctrl_i  (ctrl[i]),
         .rem_u_o (rem_u[i+1]),
         .rem_v_o (rem_v[i+1]),
         .quo_u_o (quo_u[i+1]),
         .quo_v_o (quo_v[i+1]),
         .den_o   (den[i+1]),
         .ctrl_o  (ctrl[i+1])
      );
   end

   // final remainders are not needed
   logic [COMP_WIDTH-1:0] rem_unused;
   assign rem_unused = rem_u[FRAC_BITS] ^ rem_v[FRAC_BITS] ^ den[FRAC_BITS];

   // sign and wrap to the output width
   logic [XW-1:0]          ext_u, ext_v, full_u, full_v;
   logic [COORD_WIDTH-1:0] coord_u_in, coord_v_in, coord_u_ff, coord_v_ff;
   logic [FACE_WIDTH-1:0]  face_ff;
   logic                   valid_ff;

   always_comb begin
      ext_u      = XW'(quo_u[FRAC_BITS]);
      ext_v      = XW'(quo_v[FRAC_BITS]);
      full_u     = ctrl[FRAC_BITS].neg_u ? (~ext_u + XW'(1)) : ext_u;
      full_v     = ctrl[FRAC_BITS].neg_v ? (~ext_v + XW'(1)) : ext_v;
      coord_u_in = full_u[COORD_WIDTH-1:0];
      coord_v_in = full_v[COORD_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl[FRAC_BITS].valid;
      end
   end

   always_ff @(posedge clock) begin
      face_ff    <= ctrl[FRAC_BITS].face;
      coord_u_ff <= coord_u_in;
      coord_v_ff <= coord_v_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_face    = face_ff;
   assign rsp_coord_u = $signed(coord_u_ff);
   assign rsp_coord_v = $signed(coord_v_ff);

   // every result traces back to a matching earlier input transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result strobe without a matching input transfer");

   // zero vector must give zero coordinates
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_face == FACE_NONE)) |-> ((rsp_coord_u == '0) && (rsp_coord_v == '0)))
      else $error("zero vector with nonzero coordinates");

   // face code seven is never produced
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_face <= FACE_NEG_X))
      else $error("face code out of range");

   // the zero-vector marker leaves stage b only with a unit divisor
   assert property (@(posedge clock) disable iff (reset)
      (ctrl[0].valid && (ctrl[0].face == FACE_NONE)) |-> (den[0] == COMP_WIDTH'(1)))
      else $error("zero vector entered the divider without a unit divisor");

endmodule

`default_nettype wire
